### sv/tlptw_pkg.sv
`timescale 1ns / 1ps

package tlptw_pkg;

  // Item opcodes
  typedef enum logic {
    OP_TRANSLATE = 1'b0,
    OP_REPLY     = 1'b1
  } tlptw_op_e;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_READ  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_DONE  = 2'd2,
    KIND_FAULT = 2'd3
  } tlptw_kind_e;

  // Access kind that counts as a write
  localparam logic [1:0] ACC_WRITE = 2'd1;

  // Configuration register indexes
  localparam logic [1:0] REG_PAGING_ENABLE  = 2'd0;
  localparam logic [1:0] REG_WRITE_PROTECT  = 2'd1;
  localparam logic [1:0] REG_LARGE_PAGES    = 2'd2;
  localparam logic [1:0] REG_DIRECTORY_BASE = 2'd3;

  // Address split
  localparam int unsigned DIR_SHIFT  = 22;
  localparam int unsigned PAGE_SHIFT = 12;
  localparam int unsigned IDX_BITS   = 10;
  localparam int unsigned ENTRY_SIZE = 4;

  // Entry bits
  localparam int unsigned BIT_P  = 0;
  localparam int unsigned BIT_RW = 1;
  localparam int unsigned BIT_US = 2;
  localparam int unsigned BIT_A  = 5;
  localparam int unsigned BIT_D  = 6;
  localparam int unsigned BIT_PS = 7;

  localparam logic [31:0] MASK_A = 32'h1 << BIT_A;
  localparam logic [31:0] MASK_D = 32'h1 << BIT_D;

  typedef struct packed {
    logic        paging_enable;
    logic        write_protect;
    logic        large_pages_enable;
    logic [19:0] directory_base;
  } tlptw_cfg_t;

  typedef struct packed {
    tlptw_op_e   opcode;
    logic [31:0] linear_address;
    logic [1:0]  access_kind;
    logic        user_mode;
    logic [31:0] reply_data;
  } tlptw_req_t;

  typedef struct packed {
    tlptw_kind_e kind;
    logic [31:0] address;
    logic [31:0] write_data;
    logic        writable;
    logic [2:0]  fault_code;
    logic        large_page;
    logic        last;
  } tlptw_res_t;

  // One classified item: optional entry write-backs, then the final result
  typedef struct packed {
    logic        dir_wb;
    logic [31:0] dir_addr;
    logic [31:0] dir_data;
    logic        leaf_wb;
    logic [31:0] leaf_addr;
    logic [31:0] leaf_data;
    tlptw_res_t  fin;
  } tlptw_job_t;

endpackage

### sv/tlptw_stream_if.sv
`timescale 1ns / 1ps

interface tlptw_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### sv/tlptw_front.sv
`timescale 1ns / 1ps

module tlptw_front import tlptw_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  tlptw_cfg_t cfg_i,
  tlptw_stream_if.sink req_if,
  input  logic       full_i,
  output logic       push_o,
  output tlptw_job_t job_o
);

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_DIR   = 2'd1,
    PH_TABLE = 2'd2
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [31:0] lin_q, lin_d;
  logic [1:0]  acc_q, acc_d;
  logic        usr_q, usr_d;
  logic [31:0] pde_q, pde_d;
  logic [31:0] pda_q, pda_d;

  logic accept;

  assign req_if.ready = !full_i;
  assign accept       = req_if.valid && !full_i;

  // Classify the item and build its job
  always_comb begin
    logic [31:0] data;
    logic [31:0] perms;
    logic [31:0] leaf;
    logic [31:0] leaf_addr;
    logic [31:0] phys;
    logic [31:0] nl;
    logic [31:0] table_addr;
    logic        big_page;
    logic        do_finish;
    logic        do_fault;
    logic        prot;
    logic        wr_acc;
    logic        rw;

    phase_d = phase_q;
    lin_d   = lin_q;
    acc_d   = acc_q;
    usr_d   = usr_q;
    pde_d   = pde_q;
    pda_d   = pda_q;
    push_o  = 1'b0;
    job_o   = '0;
    job_o.fin.last = 1'b1;

    data       = req_if.data.reply_data;
    perms      = '0;
    leaf       = '0;
    leaf_addr  = '0;
    phys       = '0;
    nl         = '0;
    big_page   = 1'b0;
    do_finish  = 1'b0;
    do_fault   = 1'b0;
    prot       = 1'b0;
    wr_acc     = (acc_q == ACC_WRITE);
    rw         = 1'b0;
    table_addr = {data[31:PAGE_SHIFT], lin_q[DIR_SHIFT-1:PAGE_SHIFT], 2'b00};

    if (accept) begin
      unique case (req_if.data.opcode)
        OP_TRANSLATE: begin
          push_o = 1'b1;
          if (!cfg_i.paging_enable) begin
            phase_d              = PH_IDLE;
            job_o.fin.kind       = KIND_DONE;
            job_o.fin.address    = req_if.data.linear_address;
            job_o.fin.writable   = 1'b1;
          end else begin
            lin_d   = req_if.data.linear_address;
            acc_d   = req_if.data.access_kind;
            usr_d   = req_if.data.user_mode;
            pda_d   = {cfg_i.directory_base,
                       req_if.data.linear_address[31:DIR_SHIFT], 2'b00};
            phase_d = PH_DIR;
            job_o.fin.kind    = KIND_READ;
            job_o.fin.address = pda_d;
          end
        end
        OP_REPLY: begin
          unique case (phase_q)
            PH_DIR: begin
              push_o = 1'b1;
              if (!data[BIT_P]) begin
                do_fault = 1'b1;
              end else if (data[BIT_PS] && cfg_i.large_pages_enable) begin
                pde_d     = data;
                perms     = data;
                leaf      = data;
                leaf_addr = pda_q;
                phys      = {data[31:DIR_SHIFT], lin_q[DIR_SHIFT-1:0]};
                big_page  = 1'b1;
                do_finish = 1'b1;
              end else begin
                pde_d   = data;
                phase_d = PH_TABLE;
                job_o.fin.kind    = KIND_READ;
                job_o.fin.address = table_addr;
              end
            end
            PH_TABLE: begin
              push_o = 1'b1;
              if (!data[BIT_P]) begin
                do_fault = 1'b1;
              end else begin
                perms     = pde_q & data;
                leaf      = data;
                leaf_addr = {pde_q[31:PAGE_SHIFT], lin_q[DIR_SHIFT-1:PAGE_SHIFT], 2'b00};
                phys      = {data[31:PAGE_SHIFT], lin_q[PAGE_SHIFT-1:0]};
                do_finish = 1'b1;
              end
            end
            default: begin
              // reply with no walk in flight: dropped
              phase_d = PH_IDLE;
            end
          endcase
        end
        default: phase_d = phase_q;
      endcase
    end

    // Permission checks and accessed/dirty write-back
    if (do_finish) begin
      rw = perms[BIT_RW] || (!usr_q && !cfg_i.write_protect);
      if (usr_q && !perms[BIT_US]) begin
        do_fault = 1'b1;
        prot     = 1'b1;
      end else if (wr_acc && !rw) begin
        do_fault = 1'b1;
        prot     = 1'b1;
      end else begin
        nl = leaf | MASK_A | (wr_acc ? MASK_D : 32'h0);
        job_o.dir_wb         = !big_page && !pde_q[BIT_A];
        job_o.dir_addr       = pda_q;
        job_o.dir_data       = pde_q | MASK_A;
        job_o.leaf_wb        = (nl != leaf);
        job_o.leaf_addr      = leaf_addr;
        job_o.leaf_data      = nl;
        job_o.fin.kind       = KIND_DONE;
        job_o.fin.address    = phys;
        job_o.fin.writable   = rw && nl[BIT_D];
        job_o.fin.large_page = big_page;
        phase_d              = PH_IDLE;
      end
    end

    if (do_fault) begin
      job_o.dir_wb         = 1'b0;
      job_o.leaf_wb        = 1'b0;
      job_o.fin.kind       = KIND_FAULT;
      job_o.fin.address    = lin_q;
      job_o.fin.writable   = 1'b0;
      job_o.fin.large_page = 1'b0;
      job_o.fin.fault_code = {usr_q, wr_acc, prot};
      phase_d              = PH_IDLE;
    end
  end

  // Walk state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      lin_q   <= '0;
      acc_q   <= '0;
      usr_q   <= 1'b0;
      pde_q   <= '0;
      pda_q   <= '0;
    end else begin
      phase_q <= phase_d;
      lin_q   <= lin_d;
      acc_q   <= acc_d;
      usr_q   <= usr_d;
      pde_q   <= pde_d;
      pda_q   <= pda_d;
    end
  end

endmodule

### sv/tlptw_fifo.sv
`timescale 1ns / 1ps

module tlptw_fifo import tlptw_pkg::*; #(
  parameter int unsigned DEPTH = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  tlptw_job_t job_i,
  output logic       full_o,
  input  logic       pop_i,
  output logic       valid_o,
  output tlptw_job_t job_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  tlptw_job_t       mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign job_o   = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

### sv/tlptw_back.sv
`timescale 1ns / 1ps

module tlptw_back import tlptw_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       job_valid_i,
  input  tlptw_job_t job_i,
  output logic       pop_o,
  tlptw_stream_if.source res_if
);

  tlptw_job_t job_q, job_d;
  logic       job_valid_q, job_valid_d;
  logic       dir_pend_q, dir_pend_d;
  logic       leaf_pend_q, leaf_pend_d;
  tlptw_res_t out_q, out_d;
  logic       out_valid_q, out_valid_d;

  logic       load;
  logic       fin_step;
  logic       take;
  tlptw_res_t next_res;

  assign res_if.valid = out_valid_q;
  assign res_if.data  = out_q;

  // Output register frees when empty or taken
  assign load     = !out_valid_q || res_if.ready;
  assign fin_step = job_valid_q && load && !dir_pend_q && !leaf_pend_q;
  assign take     = !job_valid_q || fin_step;
  assign pop_o    = take && job_valid_i;

  // Pick the next result of the current job
  always_comb begin
    next_res = '0;
    priority if (dir_pend_q) begin
      next_res.kind       = KIND_WRITE;
      next_res.address    = job_q.dir_addr;
      next_res.write_data = job_q.dir_data;
    end else if (leaf_pend_q) begin
      next_res.kind       = KIND_WRITE;
      next_res.address    = job_q.leaf_addr;
      next_res.write_data = job_q.leaf_data;
    end else begin
      next_res = job_q.fin;
    end
  end

  // Job sequencing
  always_comb begin
    job_d       = job_q;
    job_valid_d = job_valid_q;
    dir_pend_d  = dir_pend_q;
    leaf_pend_d = leaf_pend_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;

    if (load) begin
      out_valid_d = job_valid_q;
      if (job_valid_q) begin
        out_d = next_res;
      end
    end

    if (take) begin
      job_valid_d = job_valid_i;
      if (job_valid_i) begin
        job_d       = job_i;
        dir_pend_d  = job_i.dir_wb;
        leaf_pend_d = job_i.leaf_wb;
      end
    end else if (load) begin
      if (dir_pend_q) begin
        dir_pend_d = 1'b0;
      end else begin
        leaf_pend_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_valid_q <= 1'b0;
      dir_pend_q  <= 1'b0;
      leaf_pend_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      job_valid_q <= job_valid_d;
      dir_pend_q  <= dir_pend_d;
      leaf_pend_q <= leaf_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    job_q <= job_d;
    out_q <= out_d;
  end

endmodule

### sv/two_level_page_table_walker.sv
`timescale 1ns / 1ps

// Two-level 32-bit page table walker with optional 4 MiB pages. A translate
// request starts a walk (or passes straight through with paging off); each
// memory reply advances it. The front end takes one item per cycle whenever
// its job queue has room and turns it into a job of one to three results
// (entry write-backs for accessed/dirty bits, then a read request, done or
// fault result, flagged last). The back end sends one result per cycle while
// the result port is ready. The first result of an item is written to the
// queue at the transfer edge, then to the job and output registers.
// A reply with no walk in flight is taken and dropped.
// Configuration sits on the APB port: register 0 paging enable, 4 write
// protect, 8 large pages enable, 12 directory base frame.

module two_level_page_table_walker import tlptw_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  tlptw_stream_if.sink   req_if,
  tlptw_stream_if.source res_if
);

  tlptw_cfg_t cfg_q, cfg_d;
  logic       cfg_wr;
  logic       push, full, pop, job_valid;
  tlptw_job_t push_job, pop_job;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  // Register write
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_PAGING_ENABLE:  cfg_d.paging_enable      = pwdata[0];
        REG_WRITE_PROTECT:  cfg_d.write_protect      = pwdata[0];
        REG_LARGE_PAGES:    cfg_d.large_pages_enable = pwdata[0];
        REG_DIRECTORY_BASE: cfg_d.directory_base     = pwdata[19:0];
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Register read
  always_comb begin
    unique case (paddr[3:2])
      REG_PAGING_ENABLE:  prdata = {31'd0, cfg_q.paging_enable};
      REG_WRITE_PROTECT:  prdata = {31'd0, cfg_q.write_protect};
      REG_LARGE_PAGES:    prdata = {31'd0, cfg_q.large_pages_enable};
      REG_DIRECTORY_BASE: prdata = {12'd0, cfg_q.directory_base};
      default:            prdata = '0;
    endcase
  end

  tlptw_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .req_if (req_if),
    .full_i (full),
    .push_o (push),
    .job_o  (push_job)
  );

  tlptw_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (job_valid),
    .job_o   (pop_job)
  );

  tlptw_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_i       (pop_job),
    .pop_o       (pop),
    .res_if      (res_if)
  );

endmodule

### sv/tlptw_checker.sv
`timescale 1ns / 1ps

module tlptw_checker import tlptw_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       res_valid_i,
  input logic       res_ready_i,
  input tlptw_res_t res_data_i
);

  // A stalled result holds
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_data_i))
    else $error("result changed while stalled");

  // Entry write-backs always precede the final result of an item
  a_write_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_data_i.kind == KIND_WRITE |-> !res_data_i.last)
    else $error("write request flagged last");

  // Done and fault end the item
  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && (res_data_i.kind == KIND_DONE || res_data_i.kind == KIND_FAULT)
    |-> res_data_i.last)
    else $error("done or fault not flagged last");

  // Memory requests address whole entries
  a_entry_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && (res_data_i.kind == KIND_READ || res_data_i.kind == KIND_WRITE)
    |-> res_data_i.address[1:0] == 2'b00)
    else $error("unaligned entry address");

  // Faults carry no translation attributes
  a_fault_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_data_i.kind == KIND_FAULT
    |-> res_data_i.write_data == '0 && !res_data_i.writable && !res_data_i.large_page)
    else $error("fault with translation attributes");

endmodule

bind two_level_page_table_walker tlptw_checker u_tlptw_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .res_valid_i (res_if.valid),
  .res_ready_i (res_if.ready),
  .res_data_i  (res_if.data)
);
